// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the ray caster RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define VGRC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vgrc: same-cycle check failed");

// next-cycle implication, checked out of reset
`define VGRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vgrc: next-cycle check failed");

`endif

// ----- rtl/core/vgrc_pkg.sv -----
// Widths, constants and shared types of the vertical gridline ray caster
package vgrc_pkg;

    localparam int MAP_SIDE  = 64;
    localparam int MAX_STEPS = 8;

    localparam int MAP_BITS = $clog2(MAP_SIDE);
    localparam int ADDR_W   = 2 * MAP_BITS;
    localparam int STEP_W   = $clog2(MAX_STEPS + 1);

    localparam int CELL_W     = 6;
    localparam int GRID_W     = 7;
    localparam int POS_W      = 20;
    localparam int DIR_W      = 2;
    localparam int TAN_W      = 23;
    localparam int COORD_W    = 22;
    localparam int DIST_W     = 25;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam int CELL_SHIFT = 14;
    localparam int CELL_Q8    = 1 << CELL_SHIFT;
    localparam int TAN_SHIFT  = 12;
    localparam int ROUND_BIAS = 1 << (TAN_SHIFT - 1);

    localparam int TRAVEL_BITS = (STEP_W + CELL_SHIFT > POS_W) ? STEP_W + CELL_SHIFT : POS_W;
    localparam int RX_W        = TRAVEL_BITS + 2;
    localparam int RY_W        = TAN_W + 3 + STEP_W;

    localparam int SPAN_BITS = (MAP_BITS + CELL_SHIFT > POS_W) ? MAP_BITS + CELL_SHIFT : POS_W;
    localparam int DX_W      = SPAN_BITS + 1;
    localparam int MUL_W     = (DX_W > TAN_W) ? DX_W : TAN_W;
    localparam int PROD_W    = 2 * MUL_W;

    localparam int SQ_W       = 2 * SPAN_BITS + 1;
    localparam int ROOT_W     = SPAN_BITS + 1;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 3;
    localparam int ROOT_CNT_W = $clog2(ROOT_W);

    localparam int NO_HIT_DIST = 25600000;
    localparam int COORD_MAX   = (1 << (COORD_W - 1)) - 1;
    localparam int COORD_MIN   = -(1 << (COORD_W - 1));

    localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(64);

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_CAST  = 1'b1;

    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
    localparam logic [DIR_W-1:0] DIR_VERT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_SPARE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic              data;
    } map_wr_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_stat_t;

endpackage

// ----- rtl/core/vgrc_map_ram.sv -----
// Wall bitmap memory: one write port, one registered read port
module vgrc_map_ram (
    input  logic                          clk,
    input  vgrc_pkg::map_wr_t             wr,
    input  logic [vgrc_pkg::ADDR_W-1:0]   raddr,
    output logic                          rdata
);
    import vgrc_pkg::*;

    logic mem [2**ADDR_W];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/vgrc_mul.sv -----
// Shared signed multiplier with registered product
module vgrc_mul (
    input  logic                               clk,
    input  logic signed [vgrc_pkg::MUL_W-1:0]  a,
    input  logic signed [vgrc_pkg::MUL_W-1:0]  b,
    output logic signed [vgrc_pkg::PROD_W-1:0] p
);
    import vgrc_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// ----- rtl/core/vgrc_isqrt.sv -----
// Iterative integer square root, one result bit per cycle
module vgrc_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [vgrc_pkg::SQ_W-1:0]     radicand,
    output vgrc_pkg::sqrt_stat_t          stat,
    output logic [vgrc_pkg::ROOT_W-1:0]   root
);
    import vgrc_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [ROOT_CNT_W-1:0] cnt_reg;
    logic [RAD_W-1:0]      rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [ROOT_W-1:0]     root_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= ROOT_CNT_W'(ROOT_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - ROOT_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= RAD_W'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

// ----- rtl/core/vertical_grid_ray_caster.sv -----
// Ray caster top level: map sweep, cast sequencer and result register
//
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_we                 cfg_index, cfg_data
// in       in         in_valid / in_ready    mode, cell_col, cell_row, cell_is_wall,
//                                            player_x, player_y, ray_dir, neg_tan
// out      out        out_valid / out_ready  hit, hit_x, hit_y, ray_distance
//
// A map write is taken in S_IDLE, which it does not leave; a vertical ray goes from S_IDLE to S_DONE.
// A cast reads each probe through the single map RAM read port (S_PROBE, then S_CHECK); a
// hit goes on through S_SQX, S_SQY, S_SUM and S_ROOT, the square root unit resolving one
// bit a cycle. After reset in_ready stays low while the map's 2**ADDR_W (4096) cells are
// swept to open; cfg writes are taken throughout.
// in_ready is low from a cast transfer until its result is loaded into the output
// register, which waits for the previous result to be taken.
module vertical_grid_ray_caster (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [vgrc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vgrc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  mode,
    input  logic [vgrc_pkg::CELL_W-1:0]           cell_col,
    input  logic [vgrc_pkg::CELL_W-1:0]           cell_row,
    input  logic                                  cell_is_wall,
    input  logic [vgrc_pkg::POS_W-1:0]            player_x,
    input  logic [vgrc_pkg::POS_W-1:0]            player_y,
    input  logic [vgrc_pkg::DIR_W-1:0]            ray_dir,
    input  logic signed [vgrc_pkg::TAN_W-1:0]     neg_tan,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  hit,
    output logic signed [vgrc_pkg::COORD_W-1:0]   hit_x,
    output logic signed [vgrc_pkg::COORD_W-1:0]   hit_y,
    output logic [vgrc_pkg::DIST_W-1:0]           ray_distance
);
    import vgrc_pkg::*;

`include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_START,
        S_PROBE,
        S_CHECK,
        S_SQX,
        S_SQY,
        S_SUM,
        S_ROOT,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic                out_valid_reg, out_valid_next;
    logic [GRID_W-1:0]   grid_width_reg;
    logic [GRID_W-1:0]   grid_height_reg;

    logic [POS_W-1:0]        px_reg, px_next;
    logic [POS_W-1:0]        py_reg, py_next;
    logic signed [TAN_W-1:0] t_reg, t_next;
    logic                    left_reg, left_next;
    logic signed [RX_W-1:0]  rx_reg, rx_next;
    logic signed [RY_W-1:0]  ry_reg, ry_next;
    logic signed [RY_W-1:0]  ys_reg, ys_next;
    logic [SQ_W-1:0]         acc_reg, acc_next;
    logic                    inmap_reg, inmap_next;
    logic                    hit_flag_reg, hit_flag_next;
    logic                    load_out;

    logic                       hit_reg;
    logic signed [COORD_W-1:0]  hit_x_reg;
    logic signed [COORD_W-1:0]  hit_y_reg;
    logic [DIST_W-1:0]          dist_reg;

    logic signed [RX_W-1:0]   px_base;
    logic signed [RX_W-1:0]   start_x;
    logic signed [RY_W-1:0]   ys4;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [RY_W-1:0]   ry_start;
    logic signed [MUL_W-1:0]  diff_x;
    logic signed [MUL_W-1:0]  diff_y;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;

    logic [RX_W-CELL_SHIFT-2:0] col_u;
    logic [RY_W-CELL_SHIFT-2:0] row_u;
    logic                       probe_inmap;
    logic [ADDR_W-1:0]          probe_addr;

    map_wr_t           map_wr;
    logic              map_rdata;
    sqrt_stat_t        sqrt_stat;
    logic [ROOT_W-1:0] sqrt_root;
    logic [SQ_W-1:0]   sqrt_rad;
    logic [DIST_W-1:0] dist_sat;
    logic              in_fire;

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [RY_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > RY_W'(COORD_MAX))
        begin
            r = COORD_W'(COORD_MAX);
        end
        else if (v < RY_W'(COORD_MIN))
        begin
            r = COORD_W'(COORD_MIN);
        end
        else
        begin
            r = COORD_W'(v);
        end
        return r;
    endfunction

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_RESET;
            grid_height_reg <= GRID_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= GRID_W'(cfg_data);
                REG_GRID_HEIGHT: grid_height_reg <= GRID_W'(cfg_data);
                default:         ;
            endcase
        end
    end

    // cast start point and per-step y increment
    assign px_base = $signed(RX_W'({player_x[POS_W-1:CELL_SHIFT], CELL_SHIFT'(0)}));
    assign start_x = (ray_dir == DIR_LEFT) ? px_base - RX_W'(1) : px_base + RX_W'(CELL_Q8);
    assign ys4     = RY_W'(neg_tan) <<< 2;

    assign diff_x   = MUL_W'($signed(RY_W'(px_reg)) - RY_W'(rx_reg));
    assign diff_y   = MUL_W'($signed(RY_W'(py_reg)) - ry_reg);
    assign prod_rnd = mul_p + PROD_W'(ROUND_BIAS);
    assign ry_start = $signed(RY_W'(py_reg)) + RY_W'(prod_rnd >>> TAN_SHIFT);

    always_comb
    begin
        case (state_reg)
            S_MUL:
            begin
                mul_a = diff_x;
                mul_b = MUL_W'(t_reg);
            end
            S_SQX:
            begin
                mul_a = diff_x;
                mul_b = diff_x;
            end
            S_SQY:
            begin
                mul_a = diff_y;
                mul_b = diff_y;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    vgrc_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // probe cell from the current ray point
    assign col_u = rx_reg[RX_W-2:CELL_SHIFT];
    assign row_u = ry_reg[RY_W-2:CELL_SHIFT];
    assign probe_inmap = !rx_reg[RX_W-1] && !ry_reg[RY_W-1]
                      && (RY_W'(col_u) < RY_W'(grid_width_reg))
                      && (RY_W'(row_u) < RY_W'(grid_height_reg))
                      && (RY_W'(col_u) < RY_W'(MAP_SIDE))
                      && (RY_W'(row_u) < RY_W'(MAP_SIDE));
    assign probe_addr = {MAP_BITS'(row_u), MAP_BITS'(col_u)};

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            map_wr.en   = 1'b1;
            map_wr.addr = clr_addr_reg;
            map_wr.data = 1'b0;
        end
        else
        begin
            map_wr.en   = in_fire && (mode == MODE_WRITE)
                       && (RY_W'(cell_col) < RY_W'(MAP_SIDE))
                       && (RY_W'(cell_row) < RY_W'(MAP_SIDE));
            map_wr.addr = {MAP_BITS'(cell_row), MAP_BITS'(cell_col)};
            map_wr.data = cell_is_wall;
        end
    end

    vgrc_map_ram u_map (
        .clk   (clk),
        .wr    (map_wr),
        .raddr (probe_addr),
        .rdata (map_rdata)
    );

    assign sqrt_rad = acc_reg + SQ_W'(mul_p);

    vgrc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_SUM),
        .radicand (sqrt_rad),
        .stat     (sqrt_stat),
        .root     (sqrt_root)
    );

    assign dist_sat = (DIST_W'(sqrt_root) > DIST_W'(NO_HIT_DIST)) ? DIST_W'(NO_HIT_DIST)
                                                                   : DIST_W'(sqrt_root);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        load_out       = 1'b0;
        px_next        = px_reg;
        py_next        = py_reg;
        t_next         = t_reg;
        left_next      = left_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        ys_next        = ys_reg;
        acc_next       = acc_reg;
        inmap_next     = inmap_reg;
        hit_flag_next  = hit_flag_reg;

        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && (mode == MODE_CAST))
                begin
                    px_next       = player_x;
                    py_next       = player_y;
                    t_next        = neg_tan;
                    left_next     = (ray_dir == DIR_LEFT);
                    ys_next       = (ray_dir == DIR_LEFT) ? ys4 : -ys4;
                    hit_flag_next = 1'b0;
                    if ((ray_dir == DIR_LEFT) || (ray_dir == DIR_RIGHT))
                    begin
                        rx_next    = start_x;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        rx_next    = $signed(RX_W'(player_x));
                        ry_next    = $signed(RY_W'(player_y));
                        state_next = S_DONE;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                ry_next    = ry_start;
                step_next  = '0;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                inmap_next = probe_inmap;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (inmap_reg && map_rdata)
                begin
                    hit_flag_next = 1'b1;
                    state_next    = S_SQX;
                end
                else
                begin
                    rx_next = left_reg ? rx_reg - RX_W'(CELL_Q8) : rx_reg + RX_W'(CELL_Q8);
                    ry_next = ry_reg + ys_reg;
                    if (step_reg == STEP_W'(MAX_STEPS - 1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        step_next  = step_reg + STEP_W'(1);
                        state_next = S_PROBE;
                    end
                end
            end
            S_SQX:
            begin
                state_next = S_SQY;
            end
            S_SQY:
            begin
                acc_next   = SQ_W'(mul_p);
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (sqrt_stat.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            step_reg      <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg       <= px_next;
        py_reg       <= py_next;
        t_reg        <= t_next;
        left_reg     <= left_next;
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        ys_reg       <= ys_next;
        acc_reg      <= acc_next;
        inmap_reg    <= inmap_next;
        hit_flag_reg <= hit_flag_next;
        if (load_out)
        begin
            hit_reg   <= hit_flag_reg;
            hit_x_reg <= sat_coord(RY_W'(rx_reg));
            hit_y_reg <= sat_coord(ry_reg);
            dist_reg  <= hit_flag_reg ? dist_sat : DIST_W'(NO_HIT_DIST);
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign hit_x        = hit_x_reg;
    assign hit_y        = hit_y_reg;
    assign ray_distance = dist_reg;

    `VGRC_ASSERT_IMP(a_step_bound, state_reg == S_CHECK, step_reg < STEP_W'(MAX_STEPS))
    `VGRC_ASSERT_IMP(a_miss_dist, out_valid && !hit, ray_distance == DIST_W'(NO_HIT_DIST))
    `VGRC_ASSERT_IMP(a_idle_sqrt, in_ready, !sqrt_stat.busy)
    `VGRC_ASSERT_NEXT(a_sqrt_start, state_reg == S_SUM, sqrt_stat.busy)
    `VGRC_ASSERT_IMP(a_clear_write, state_reg == S_CLEAR, map_wr.en && !map_wr.data)

endmodule
